/* rtl/dfrb_pkg.sv */
// Shared types and constants for the delimited frame ring buffer.
package dfrb_pkg;

    localparam int P_DEPTH = 256;

    typedef logic [7:0] t_byte;

    localparam logic       OP_PUSH = 1'b0;
    localparam logic       OP_POP  = 1'b1;

    localparam logic [1:0] K_ACK    = 2'd0;
    localparam logic [1:0] K_BYTE   = 2'd1;
    localparam logic [1:0] K_STATUS = 2'd2;

    localparam logic       ST_OK    = 1'b0;
    localparam logic       ST_ERR   = 1'b1;

    localparam t_byte      ERASED_BYTE = 8'hFF;
    localparam int         SIZE_MAX    = 511;

    typedef struct packed {
        logic       operation;
        t_byte      data_byte;
        logic       end_of_chunk;
        logic [5:0] max_length;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        t_byte      frame_byte;
        logic       accepted;
        logic       status;
        logic [8:0] frame_size;
        logic       last;
    } t_out;

endpackage

/* rtl/dfrb_ram.sv */
// Generic simple dual-port RAM with registered read.
module dfrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/delimited_frame_ring_buffer.sv */
// Top level: byte ring buffer holding delimiter-terminated frames.
//
// Each input transfer is a push or a pop. A push returns one acknowledge. A pop
// scans the ring one entry per cycle from the read pointer until the first
// delimiter (limited by the single read port of the byte store), then delivers
// up to max_length frame bytes, each by a memory read and then the output
// register, and closes with one status transfer; a pop on an empty ring answers
// with the status transfer alone. Entries that were never written read as 0xFF,
// tracked by the write pointer and a wrap flag, so no clearing pass is needed
// after reset. The delimiter register is written only while no pop is in
// progress and takes effect on the next transfer.
module delimited_frame_ring_buffer #(
    parameter int DEPTH = dfrb_pkg::P_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  dfrb_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output dfrb_pkg::t_out  o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  dfrb_pkg::t_byte i_cfg_data
);
    import dfrb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_READ = 5'b00100,
        S_EMIT = 5'b01000,
        S_STAT = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_rd, n_rd, r_wr, n_wr, r_p, n_p, r_found, n_found, r_raddr_q;
    logic            r_wrapped, n_wrapped, r_stopped, n_stopped;
    logic            r_empty, n_empty, r_ok, n_ok;
    logic [NW-1:0]   r_n, n_n;
    logic [5:0]      r_maxlen, n_maxlen, r_lim, n_lim, r_k, n_k;
    t_byte           r_delim;
    logic            r_ov, n_ov;
    t_out            r_out, n_out;

    logic            in_acc, out_free, ram_we;
    logic [AW-1:0]   raddr;
    t_byte           rdata, byte_eff;
    logic [8:0]      size_sat;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
        adv = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    dfrb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr),
        .i_wdata (i_in_data.data_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign out_free    = !r_ov || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign o_cfg_ready = i_rst_n && (r_state == S_IDLE);

    assign raddr    = (r_state == S_IDLE) ? r_rd : r_p;
    assign byte_eff = (r_wrapped || (r_raddr_q < r_wr)) ? rdata : ERASED_BYTE;
    assign size_sat = (32'(r_n) > SIZE_MAX) ? 9'(SIZE_MAX) : 9'(r_n);

    always_comb begin
        n_state   = r_state;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_p       = r_p;
        n_found   = r_found;
        n_wrapped = r_wrapped;
        n_stopped = r_stopped;
        n_empty   = r_empty;
        n_ok      = r_ok;
        n_n       = r_n;
        n_maxlen  = r_maxlen;
        n_lim     = r_lim;
        n_k       = r_k;
        n_ov      = r_ov && i_out_stall;
        n_out     = r_out;
        ram_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.operation == OP_PUSH) begin
                        n_ov  = 1'b1;
                        n_out = '{kind: K_ACK, frame_byte: '0, accepted: !r_stopped,
                                  status: ST_OK, frame_size: '0, last: 1'b1};
                        if (!r_stopped) begin
                            ram_we = 1'b1;
                            n_wr   = adv(r_wr);
                            if (r_wr == AW'(DEPTH - 1)) begin
                                n_wrapped = 1'b1;
                            end
                            if (i_in_data.data_byte == r_delim) begin
                                n_stopped = 1'b1;
                            end
                        end
                        if (i_in_data.end_of_chunk) begin
                            n_stopped = 1'b0;
                        end
                    end else begin
                        n_maxlen = i_in_data.max_length;
                        if (r_rd == r_wr) begin
                            n_empty = 1'b1;
                            n_state = S_STAT;
                        end else begin
                            n_empty = 1'b0;
                            n_p     = adv(r_rd);
                            n_n     = NW'(1);
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (byte_eff == r_delim) begin
                    n_found = r_raddr_q;
                    n_p     = r_rd;
                    n_k     = '0;
                    if (32'(r_n) <= 32'(r_maxlen)) begin
                        n_ok  = 1'b1;
                        n_lim = 6'(r_n);
                    end else begin
                        n_ok  = 1'b0;
                        n_lim = r_maxlen;
                    end
                    n_state = S_READ;
                end else if (r_p == r_wr) begin
                    n_empty = 1'b1;
                    n_state = S_STAT;
                end else begin
                    n_p = adv(r_p);
                    n_n = r_n + NW'(1);
                end
            end
            S_READ: begin
                n_state = (r_k == r_lim) ? S_STAT : S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_out   = '{kind: K_BYTE, frame_byte: byte_eff, accepted: 1'b0,
                                status: ST_OK, frame_size: '0, last: 1'b0};
                    n_k     = r_k + 6'd1;
                    n_p     = adv(r_p);
                    n_state = S_READ;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_out = '{kind: K_STATUS, frame_byte: '0, accepted: 1'b0,
                              status: (r_empty || !r_ok) ? ST_ERR : ST_OK,
                              frame_size: r_empty ? 9'd0 : size_sat, last: 1'b1};
                    if (!r_empty) begin
                        n_rd = adv(r_found);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd      <= '0;
            r_wr      <= '0;
            r_wrapped <= 1'b0;
            r_stopped <= 1'b0;
            r_delim   <= '0;
            r_ov      <= 1'b0;
            r_empty   <= 1'b0;
            r_ok      <= 1'b0;
            r_n       <= '0;
            r_k       <= '0;
            r_lim     <= '0;
        end else begin
            r_state   <= n_state;
            r_rd      <= n_rd;
            r_wr      <= n_wr;
            r_wrapped <= n_wrapped;
            r_stopped <= n_stopped;
            r_ov      <= n_ov;
            r_empty   <= n_empty;
            r_ok      <= n_ok;
            r_n       <= n_n;
            r_k       <= n_k;
            r_lim     <= n_lim;
            if (i_cfg_valid && o_cfg_ready) begin
                r_delim <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_found   <= n_found;
        r_maxlen  <= n_maxlen;
        r_out     <= n_out;
        r_raddr_q <= raddr;
    end

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd != r_wr))
        else $error("scan running on an empty ring");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_k < r_lim))
        else $error("frame byte beyond delivery limit");

    a_frame_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAT && !r_empty) |-> (r_n != '0))
        else $error("frame status with zero size");

    a_chunk_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.operation == OP_PUSH && !r_stopped
         && i_in_data.data_byte == r_delim && !i_in_data.end_of_chunk)
        |=> r_stopped)
        else $error("delimiter did not stop the chunk");

endmodule

/* bench/delimited_frame_ring_buffer_test.sv */
// Self-checking bench for the delimited frame ring buffer: directed and random pushes and pops against a model.
`timescale 1ns / 1ps

module delimited_frame_ring_buffer_test;
    import dfrb_pkg::*;

    localparam int WATCHDOG_CYCLES = 2_000_000;

    class frame_buffer_board;
        t_byte ring [P_DEPTH];
        int    rd_ptr;
        int    wr_ptr;
        bit    chunk_full;
        t_byte delimiter;
        t_out  awaited[$];
        int    failures;

        function new();
            foreach (ring[i]) ring[i] = ERASED_BYTE;
            rd_ptr     = 0;
            wr_ptr     = 0;
            chunk_full = 1'b0;
            delimiter  = 8'h00;
            failures   = 0;
        endfunction

        function int step(input int p);
            return (p + 1) % P_DEPTH;
        endfunction

        function void note_transfer(input t_in item);
            t_out  r;
            int    p;
            bit    found;
            bit    ended;
            int    taken;
            t_byte v;
            r = '0;
            if (item.operation == OP_PUSH) begin
                r.kind = K_ACK;
                r.last = 1'b1;
                if (!chunk_full) begin
                    ring[wr_ptr] = item.data_byte;
                    wr_ptr = step(wr_ptr);
                    r.accepted = 1'b1;
                    if (item.data_byte == delimiter) chunk_full = 1'b1;
                end
                if (item.end_of_chunk) chunk_full = 1'b0;
                awaited.push_back(r);
                return;
            end
            found = 1'b0;
            p = rd_ptr;
            while (p != wr_ptr && !found) begin
                if (ring[p] == delimiter) found = 1'b1;
                else p = step(p);
            end
            if (!found) begin
                r.kind   = K_STATUS;
                r.status = ST_ERR;
                r.last   = 1'b1;
                awaited.push_back(r);
                return;
            end
            taken = 0;
            ended = 1'b0;
            while (taken < int'(item.max_length) && !ended) begin
                v = ring[rd_ptr];
                rd_ptr = step(rd_ptr);
                taken++;
                r = '0;
                r.kind = K_BYTE;
                r.frame_byte = v;
                awaited.push_back(r);
                if (v == delimiter) ended = 1'b1;
            end
            // too long: skip the rest of the frame, delimiter included
            if (!ended) begin
                do begin
                    v = ring[rd_ptr];
                    rd_ptr = step(rd_ptr);
                    if (taken < SIZE_MAX) taken++;
                end while (v != delimiter);
            end
            r = '0;
            r.kind       = K_STATUS;
            r.status     = ended ? ST_OK : ST_ERR;
            r.frame_size = 9'(taken);
            r.last       = 1'b1;
            awaited.push_back(r);
        endfunction

        function void check_transfer(input t_out got);
            t_out want;
            if (awaited.size() == 0) begin
                $error("unexpected result transfer: kind %0d", got.kind);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                failures++;
            end
            if (got.frame_byte !== want.frame_byte) begin
                $error("frame_byte: expected %0h, actual %0h", want.frame_byte, got.frame_byte);
                failures++;
            end
            if (got.accepted !== want.accepted) begin
                $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
                failures++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
            if (got.frame_size !== want.frame_size) begin
                $error("frame_size: expected %0d, actual %0d", want.frame_size, got.frame_size);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_stall;
    t_in   in_data   = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    t_out  out_data;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    t_byte cfg_data  = '0;

    frame_buffer_board sb;
    bit calm      = 1'b0;
    int sent_items = 0;
    int out_wait  = 0;
    int cycles    = 0;

    delimited_frame_ring_buffer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int draw_wait();
        if (calm) return 0;
        return int'($urandom_range(0, 13));
    endfunction

    function automatic t_byte other_byte();
        t_byte b;
        b = t_byte'($urandom_range(0, 255));
        while (b == sb.delimiter) b = t_byte'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic int pick_limit();
        int r;
        r = int'($urandom_range(0, 7));
        if (r < 2) return 63;
        if (r == 2) return 0;
        return int'($urandom_range(1, 63));
    endfunction

    // result side: random stall per result transfer
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                sb.check_transfer(out_data);
                out_wait = draw_wait();
            end else if (out_valid && out_wait != 0) begin
                out_wait--;
            end
        end
        out_stall <= (out_wait != 0);
    end

    initial begin
        while (cycles < WATCHDOG_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(input t_in item);
        int gap;
        gap = draw_wait();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        sb.note_transfer(item);
        sent_items++;
    endtask

    task automatic push_byte(input t_byte value, input bit eoc);
        t_in item;
        item.operation    = OP_PUSH;
        item.data_byte    = value;
        item.end_of_chunk = eoc;
        item.max_length   = 6'($urandom_range(0, 63));
        send_item(item);
    endtask

    task automatic pop_frame(input int limit);
        t_in item;
        item.operation    = OP_POP;
        item.data_byte    = t_byte'($urandom_range(0, 255));
        item.end_of_chunk = 1'($urandom_range(0, 1));
        item.max_length   = 6'(limit);
        send_item(item);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
    endtask

    task automatic write_delimiter(input t_byte value);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.delimiter = value;
    endtask

    task automatic run_frames(input int count);
        int stop_at;
        int choice;
        int len;
        int tail;
        stop_at = sent_items + count;
        while (sent_items < stop_at) begin
            if ($urandom_range(0, 7) == 0) calm = ~calm;
            choice = int'($urandom_range(0, 19));
            if (choice < 13) begin
                len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(40, 70))
                                                  : int'($urandom_range(0, 6));
                repeat (len) push_byte(other_byte(), $urandom_range(0, 5) == 0);
                tail = int'($urandom_range(0, 2));
                push_byte(sb.delimiter, tail == 0);
                if (tail != 0) begin
                    repeat (tail - 1) push_byte(t_byte'($urandom_range(0, 255)), 1'b0);
                    push_byte(t_byte'($urandom_range(0, 255)), 1'b1);
                end
                if ($urandom_range(0, 2) != 0) pop_frame(pick_limit());
            end else if (choice < 16) begin
                pop_frame(pick_limit());
            end else if (choice < 18) begin
                push_byte(t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (choice == 18) begin
                wait_drain();
            end else begin
                repeat ($urandom_range(2, 4)) pop_frame(pick_limit());
            end
        end
    endtask

    // fill until the write pointer meets the read pointer, pop, then push one short
    // frame over the overwritten data and pop it
    task automatic flood_ring();
        int fill;
        if (sb.chunk_full) push_byte(other_byte(), 1'b1);
        fill = P_DEPTH - ((sb.wr_ptr - sb.rd_ptr + P_DEPTH) % P_DEPTH);
        repeat (fill) push_byte(other_byte(), 1'b1);
        pop_frame(63);
        push_byte(other_byte(), 1'b1);
        push_byte(other_byte(), 1'b0);
        push_byte(sb.delimiter, 1'b1);
        pop_frame(63);
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_delimiter(8'h00);
        pop_frame(63);
        push_byte(8'h12, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b1);
        push_byte(8'h00, 1'b1);
        pop_frame(63);
        pop_frame(0);
        pop_frame(1);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b1);
        pop_frame(2);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h00, 1'b1);
        pop_frame(3);
        push_byte(8'h00, 1'b1);
        pop_frame(1);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b1);
        pop_frame(63);
        push_byte(8'h00, 1'b1);
        pop_frame(63);
        run_frames(8);

        wait_drain();
        write_delimiter(8'hFF);
        run_frames(8);

        wait_drain();
        write_delimiter(t_byte'($urandom_range(1, 254)));
        flood_ring();
        run_frames(8);

        wait_drain();
        write_delimiter(t_byte'($urandom_range(0, 255)));
        run_frames(8);

        wait_drain();
        repeat (30) @(posedge clk);
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/dfrb_pkg.sv
rtl/dfrb_ram.sv
rtl/delimited_frame_ring_buffer.sv
bench/delimited_frame_ring_buffer_test.sv
